// File: design/kp_pkg.sv
// Shared package for the Keccak-p permutation block.
// Holds constants, the controller-to-datapath command type and elaboration-time
// helper functions. Depends on nothing.
`timescale 1ns / 1ps

package kp_pkg;

  // Fixed field widths and block sizes.
  localparam int KP_WORD_W      = 64;
  localparam int KP_LANE_WIDTH  = 64;
  localparam int KP_NUM_LANES   = 25;
  localparam int KP_LAST_LANE   = KP_NUM_LANES - 1;
  localparam int KP_MAX_ROUNDS  = 24;
  localparam int KP_CNT_W       = 5;
  localparam int KP_LFSR_PERIOD = 255;
  localparam int KP_ROUND_BASE  = 12;
  localparam int KP_RHO_STEPS   = 24;

  // The round constant table covers round indices from -12 to 23.
  localparam int KP_RC_OFFSET   = 12;
  localparam int KP_RC_ENTRIES  = 36;
  localparam int KP_RC_SEL_W    = 6;

  // LFSR x^8+x^6+x^5+x^4+1 feedback.
  localparam logic [8:0] KP_LFSR_POLY = 9'h171;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic                   shift;   // shift lanes down, new lane enters at the top
    logic                   round;   // apply one round to all lanes
    logic [KP_RC_SEL_W-1:0] rc_sel;  // round constant entry for this round
  } kp_cmd_t;

  // Floor of log2 of the lane width.
  function automatic int kp_log2(input int w);
    int l;
    l = 0;
    for (int i = 0; i < 7; i++) begin
      if ((2 << i) <= w) begin
        l = i + 1;
      end
    end
    return l;
  endfunction

  // Rho rotation offset of lane 5*y+x, before reduction by the lane width.
  function automatic int kp_rho_off(input int idx);
    int x;
    int y;
    int ny;
    int off;
    x   = 1;
    y   = 0;
    off = 0;
    for (int t = 0; t < KP_RHO_STEPS; t++) begin
      if (5 * y + x == idx) begin
        off = (t + 1) * (t + 2) / 2;
      end
      ny = (2 * x + 3 * y) % 5;
      x  = y;
      y  = ny;
    end
    return off;
  endfunction

  // Iota round constant for round index ir, evaluated at elaboration only.
  function automatic logic [KP_WORD_W-1:0] kp_rc(input int ir, input int l);
    logic [KP_WORD_W-1:0] rc;
    logic [8:0]           r;
    int                   k;
    rc = '0;
    for (int j = 0; j <= l; j++) begin
      k = (((j + 7 * ir) % KP_LFSR_PERIOD) + KP_LFSR_PERIOD) % KP_LFSR_PERIOD;
      r = 9'd1;
      for (int i = 0; i < k; i++) begin
        r = r << 1;
        if (r[8]) begin
          r = r ^ KP_LFSR_POLY;
        end
      end
      rc[(1 << j) - 1] = r[0];
    end
    return rc;
  endfunction

endpackage

// File: design/kp_ctrl.sv
// Controller for the Keccak-p permutation block: load, round and emit phases.
// Holds the round count register and drives the datapath through kp_cmd_t.
// Depends on kp_pkg.
`timescale 1ns / 1ps

module kp_ctrl #(
  parameter int LANE_WIDTH = kp_pkg::KP_LANE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_wr_en,
  input  logic [kp_pkg::KP_CNT_W-1:0]   cfg_wr_data,
  output kp_pkg::kp_cmd_t               cmd,
  output logic                          out_valid,
  output logic [kp_pkg::KP_CNT_W-1:0]   out_lane_index,
  output logic                          out_last_lane
);
  import kp_pkg::*;

  localparam int L       = kp_log2(LANE_WIDTH);
  // Table entry one past the last round; the first round of n sits n entries lower.
  localparam int RC_BASE = KP_ROUND_BASE + 2 * L + KP_RC_OFFSET;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  localparam logic [KP_CNT_W-1:0] LAST_IDX   = KP_CNT_W'(KP_LAST_LANE);
  localparam logic [KP_CNT_W-1:0] MAX_ROUNDS = KP_CNT_W'(KP_MAX_ROUNDS);

  logic [1:0]             state_r,     state_nxt;
  logic [KP_CNT_W-1:0]    cnt_r,       cnt_nxt;
  logic [KP_CNT_W-1:0]    round_r,     round_nxt;
  logic [KP_CNT_W-1:0]    nrounds_r,   nrounds_nxt;
  logic [KP_RC_SEL_W-1:0] rc_idx_r,    rc_idx_nxt;
  logic [KP_CNT_W-1:0]    round_cfg_r;
  logic [KP_CNT_W-1:0]    n_sat;

  // Round count register; values above the maximum saturate when used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_cfg_r <= MAX_ROUNDS;
    end else if (cfg_wr_en) begin
      round_cfg_r <= cfg_wr_data;
    end
  end

  assign n_sat = (round_cfg_r > MAX_ROUNDS) ? MAX_ROUNDS : round_cfg_r;

  // Phase sequencing.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    round_nxt   = round_r;
    nrounds_nxt = nrounds_r;
    rc_idx_nxt  = rc_idx_r;
    cmd.shift   = 1'b0;
    cmd.round   = 1'b0;
    cmd.rc_sel  = rc_idx_r;
    case (state_r)
      ST_LOAD: begin
        if (start) begin
          cmd.shift = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          if (cnt_r == LAST_IDX) begin
            cnt_nxt     = '0;
            round_nxt   = '0;
            nrounds_nxt = n_sat;
            rc_idx_nxt  = KP_RC_SEL_W'(RC_BASE) - {1'b0, n_sat};
            state_nxt   = (n_sat == '0) ? ST_EMIT : ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cmd.round  = 1'b1;
        round_nxt  = round_r + 1'b1;
        rc_idx_nxt = rc_idx_r + 1'b1;
        if (round_r == nrounds_r - 1'b1) begin
          round_nxt = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.shift = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        cnt_nxt   = '0;
        round_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      round_r   <= '0;
      nrounds_r <= '0;
      rc_idx_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      round_r   <= round_nxt;
      nrounds_r <= nrounds_nxt;
      rc_idx_r  <= rc_idx_nxt;
    end
  end

  // Status and result strobes.
  assign busy           = (state_r != ST_LOAD);
  assign out_valid      = (state_r == ST_EMIT);
  assign out_lane_index = cnt_r;
  assign out_last_lane  = (state_r == ST_EMIT) && (cnt_r == LAST_IDX);

endmodule

// File: design/kp_datapath.sv
// Datapath for the Keccak-p permutation block: 25 lane registers that shift
// for load and emit, and one full round of theta, rho, pi, chi and iota.
// Depends on kp_pkg.
`timescale 1ns / 1ps

module kp_datapath #(
  parameter int LANE_WIDTH = kp_pkg::KP_LANE_WIDTH
) (
  input  logic                          clk,
  input  kp_pkg::kp_cmd_t               cmd,
  input  logic [kp_pkg::KP_WORD_W-1:0]  in_lane_value,
  output logic [kp_pkg::KP_WORD_W-1:0]  out_lane_result
);
  import kp_pkg::*;

  localparam int L         = kp_log2(LANE_WIDTH);
  localparam int THETA_ROT = 1 % LANE_WIDTH;

  logic [LANE_WIDTH-1:0] lane_r [KP_NUM_LANES];
  logic [LANE_WIDTH-1:0] col    [5];
  logic [LANE_WIDTH-1:0] dlt    [5];
  logic [LANE_WIDTH-1:0] th     [KP_NUM_LANES];
  logic [LANE_WIDTH-1:0] rh     [KP_NUM_LANES];
  logic [LANE_WIDTH-1:0] pi     [KP_NUM_LANES];
  logic [LANE_WIDTH-1:0] rnd    [KP_NUM_LANES];
  logic [LANE_WIDTH-1:0] rc_tab [KP_RC_ENTRIES];

  // Left rotation by a fixed amount below the lane width.
  function automatic logic [LANE_WIDTH-1:0] rotl(input logic [LANE_WIDTH-1:0] v,
                                                 input int r);
    logic [2*LANE_WIDTH-1:0] d;
    d = {v, v} >> (LANE_WIDTH - r);
    return d[LANE_WIDTH-1:0];
  endfunction

  // Round constants, one entry per round index from the lowest one up.
  for (genvar g = 0; g < KP_RC_ENTRIES; g++) begin : g_rc
    localparam logic [KP_WORD_W-1:0] RC_FULL = kp_rc(g - KP_RC_OFFSET, L);
    assign rc_tab[g] = RC_FULL[LANE_WIDTH-1:0];
  end

  // Theta: column parities and their mix into every lane.
  always_comb begin
    for (int x = 0; x < 5; x++) begin
      col[x] = lane_r[x] ^ lane_r[5 + x] ^ lane_r[10 + x] ^ lane_r[15 + x]
             ^ lane_r[20 + x];
    end
    for (int x = 0; x < 5; x++) begin
      dlt[x] = col[(x + 4) % 5] ^ rotl(col[(x + 1) % 5], THETA_ROT);
    end
    for (int i = 0; i < KP_NUM_LANES; i++) begin
      th[i] = lane_r[i] ^ dlt[i % 5];
    end
  end

  // Rho: a fixed rotation per lane.
  for (genvar i = 0; i < KP_NUM_LANES; i++) begin : g_rho
    localparam int ROT = kp_rho_off(i) % LANE_WIDTH;
    assign rh[i] = rotl(th[i], ROT);
  end

  // Pi, chi and iota.
  always_comb begin
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        pi[5 * y + x] = rh[5 * x + (x + 3 * y) % 5];
      end
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        rnd[5 * y + x] = pi[5 * y + x]
                       ^ (~pi[5 * y + (x + 1) % 5] & pi[5 * y + (x + 2) % 5]);
      end
    end
    rnd[0] = rnd[0] ^ rc_tab[cmd.rc_sel];
  end

  // Lane registers: shift for load and emit, or take a whole round.
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < KP_NUM_LANES - 1; i++) begin
        lane_r[i] <= lane_r[i + 1];
      end
      lane_r[KP_NUM_LANES-1] <= in_lane_value[LANE_WIDTH-1:0];
    end else if (cmd.round) begin
      for (int i = 0; i < KP_NUM_LANES; i++) begin
        lane_r[i] <= rnd[i];
      end
    end
  end

  // The lowest lane is the one on its way out.
  assign out_lane_result = KP_WORD_W'(lane_r[0]);

endmodule

// File: design/keccak_permutation_top.sv
// Top level of the Keccak-p permutation block.
// Joins the controller kp_ctrl and the datapath kp_datapath; depends on kp_pkg.
//
//  Channel  Ports                                          Handshake
//  -------  ---------------------------------------------  ----------------------------
//  input    in_lane_value                                  start high and busy low
//  result   out_lane_result, out_lane_index, out_last_lane out_valid for one cycle
//  config   cfg_wr_data                                    cfg_wr_en, taken at once
//
// A state takes 25 load transactions, one per cycle at best. The 25th starts
// the rounds: one round per cycle through a single full-round datapath, for a
// round count n of 0 to 24. Then 25 results follow on consecutive cycles,
// lowest lane first; busy is high from the 25th load to the last result.
// Reset sets the round count to 24 and returns to loading; the receiver
// cannot stall results.
`timescale 1ns / 1ps

module keccak_permutation_top #(
  parameter int LANE_WIDTH = kp_pkg::KP_LANE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [kp_pkg::KP_WORD_W-1:0]  in_lane_value,
  input  logic                          cfg_wr_en,
  input  logic [kp_pkg::KP_CNT_W-1:0]   cfg_wr_data,
  output logic                          out_valid,
  output logic [kp_pkg::KP_WORD_W-1:0]  out_lane_result,
  output logic [kp_pkg::KP_CNT_W-1:0]   out_lane_index,
  output logic                          out_last_lane
);
  import kp_pkg::*;

  kp_cmd_t cmd;

  // Sequencing and configuration.
  kp_ctrl #(
    .LANE_WIDTH (LANE_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (cmd),
    .out_valid      (out_valid),
    .out_lane_index (out_lane_index),
    .out_last_lane  (out_last_lane)
  );

  // Lane storage and round logic.
  kp_datapath #(
    .LANE_WIDTH (LANE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .in_lane_value   (in_lane_value),
    .out_lane_result (out_lane_result)
  );

`ifndef SYNTH
  // Results only come out while the block is busy.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while not busy");

  // Results of one state come on consecutive cycles with rising lane index.
  a_emit_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_lane) |=>
      (out_valid && out_lane_index == KP_CNT_W'($past(out_lane_index) + 1'b1)))
    else $error("result sequence broken");

  // After the last lane the block goes back to loading.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_lane |=> (!out_valid && !busy))
    else $error("block still busy after the last lane");

  // Busy only drops at the end of an emit phase.
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && $past(busy)) |-> $past(out_last_lane))
    else $error("busy dropped outside the end of a state");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for keccak_permutation_top.
// Loads whole states lane by lane under several round counts and checks every permuted
// lane against an in-bench Keccak-p predictor. Depends on kp_pkg and the design.
`timescale 1ns / 1ps

module tb;
  import kp_pkg::*;

  localparam int LANE_LOG      = $clog2(KP_LANE_WIDTH);
  localparam int SETTLE_CYCLES = 2 * KP_NUM_LANES;
  localparam int TAIL_CYCLES   = 2 * KP_NUM_LANES + KP_MAX_ROUNDS;
  localparam int MAX_REPORTS   = 10;

  typedef enum logic [1:0] {
    TXN_LANE,
    TXN_CFG,
    TXN_DRAIN
  } txn_kind_t;

  typedef struct {
    txn_kind_t             kind;
    logic [KP_WORD_W-1:0]  value;
    int                    gap;
  } lane_txn_t;

  typedef struct {
    logic [KP_WORD_W-1:0]  lane;
    logic [KP_CNT_W-1:0]   idx;
    logic                  last;
  } lane_out_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [KP_WORD_W-1:0]  in_lane_value = '0;
  logic                  cfg_wr_en = 1'b0;
  logic [KP_CNT_W-1:0]   cfg_wr_data = '0;
  logic                  out_valid;
  logic [KP_WORD_W-1:0]  out_lane_result;
  logic [KP_CNT_W-1:0]   out_lane_index;
  logic                  out_last_lane;

  // Pending stimulus and the permuted lanes still to be seen at the output.
  lane_txn_t             lane_txn_q[$];
  lane_out_t             permuted_q[$];

  // Predictor state.
  logic [KP_WORD_W-1:0]  state_lanes [KP_NUM_LANES];
  logic                  lfsr_seq [KP_LFSR_PERIOD];
  logic [KP_CNT_W-1:0]   rounds_cfg;
  int                    load_cnt;
  int                    gap_cnt;
  int                    quiet_cnt;
  int                    mismatches = 0;

  keccak_permutation_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_lane_value   (in_lane_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_lane_result (out_lane_result),
    .out_lane_index  (out_lane_index),
    .out_last_lane   (out_last_lane)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Left rotation of a lane, with the amount reduced modulo the lane width.
  function automatic logic [KP_WORD_W-1:0] rotl_lane(input logic [KP_WORD_W-1:0] v,
                                                    input int r);
    int s;
    s = r % KP_LANE_WIDTH;
    if (s == 0) begin
      return v;
    end
    return (v << s) | (v >> (KP_LANE_WIDTH - s));
  endfunction

  // One full round (theta, rho, pi, chi, iota) on the predicted state.
  function automatic void apply_round(input int ir);
    logic [KP_WORD_W-1:0] col [5];
    logic [KP_WORD_W-1:0] dlt [5];
    logic [KP_WORD_W-1:0] rh [KP_NUM_LANES];
    logic [KP_WORD_W-1:0] pi_l [KP_NUM_LANES];
    logic [KP_WORD_W-1:0] rc;
    int                   x;
    int                   y;
    int                   ny;
    int                   k;
    for (int c = 0; c < 5; c++) begin
      col[c] = state_lanes[c] ^ state_lanes[5 + c] ^ state_lanes[10 + c]
             ^ state_lanes[15 + c] ^ state_lanes[20 + c];
    end
    for (int c = 0; c < 5; c++) begin
      dlt[c] = col[(c + 4) % 5] ^ rotl_lane(col[(c + 1) % 5], 1);
    end
    for (int i = 0; i < KP_NUM_LANES; i++) begin
      state_lanes[i] ^= dlt[i % 5];
    end
    // Rho walks the lanes along the (x, y) -> (y, 2x+3y) orbit.
    rh[0] = state_lanes[0];
    x = 1;
    y = 0;
    for (int t = 0; t < KP_RHO_STEPS; t++) begin
      rh[5 * y + x] = rotl_lane(state_lanes[5 * y + x], (t + 1) * (t + 2) / 2);
      ny = (2 * x + 3 * y) % 5;
      x  = y;
      y  = ny;
    end
    for (int b = 0; b < 5; b++) begin
      for (int a = 0; a < 5; a++) begin
        pi_l[5 * b + a] = rh[5 * a + (a + 3 * b) % 5];
      end
    end
    for (int b = 0; b < 5; b++) begin
      for (int a = 0; a < 5; a++) begin
        state_lanes[5 * b + a] = pi_l[5 * b + a]
          ^ (~pi_l[5 * b + (a + 1) % 5] & pi_l[5 * b + (a + 2) % 5]);
      end
    end
    // Iota: bit 2^j-1 of the constant is LFSR output j+7*ir.
    rc = '0;
    for (int j = 0; j <= LANE_LOG; j++) begin
      k = (((j + 7 * ir) % KP_LFSR_PERIOD) + KP_LFSR_PERIOD) % KP_LFSR_PERIOD;
      rc[(1 << j) - 1] = lfsr_seq[k];
    end
    state_lanes[0] ^= rc;
  endfunction

  // Takes one loaded lane; the 25th permutes the state and queues all 25 lanes.
  task automatic absorb_lane(input logic [KP_WORD_W-1:0] v);
    int        n;
    lane_out_t res;
    state_lanes[load_cnt] = v;
    load_cnt++;
    if (load_cnt == KP_NUM_LANES) begin
      n = (rounds_cfg > KP_MAX_ROUNDS) ? KP_MAX_ROUNDS : int'(rounds_cfg);
      for (int r = 0; r < n; r++) begin
        apply_round(KP_ROUND_BASE + 2 * LANE_LOG - n + r);
      end
      for (int i = 0; i < KP_NUM_LANES; i++) begin
        res.lane = state_lanes[i];
        res.idx  = KP_CNT_W'(i);
        res.last = (i == KP_LAST_LANE);
        permuted_q.push_back(res);
      end
      load_cnt = 0;
    end
  endtask

  // Idle gap before a transaction: mostly none or short, now and then long.
  function automatic int pick_gap(input bit gappy);
    int r;
    if (!gappy) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic push_txn(input txn_kind_t kind, input logic [KP_WORD_W-1:0] value,
                          input int gap);
    lane_txn_t txn;
    txn.kind  = kind;
    txn.value = value;
    txn.gap   = gap;
    lane_txn_q.push_back(txn);
  endtask

  // Queues one whole state of random lanes, or of zero lanes.
  task automatic push_state(input bit gappy, input bit zero_lanes);
    logic [KP_WORD_W-1:0] v;
    for (int i = 0; i < KP_NUM_LANES; i++) begin
      v = zero_lanes ? '0 : {$urandom(), $urandom()};
      push_txn(TXN_LANE, v, pick_gap(gappy));
    end
  endtask

  // Stimulus plan, reset and end of run.
  initial begin : stim_proc
    logic [8:0]           lfsr;
    logic [KP_WORD_W-1:0] v;
    lfsr = 9'd1;
    for (int k = 0; k < KP_LFSR_PERIOD; k++) begin
      lfsr_seq[k] = lfsr[0];
      lfsr = lfsr << 1;
      if (lfsr[8]) begin
        lfsr = lfsr ^ KP_LFSR_POLY;
      end
    end

    // Directed state under the reset round count: field extremes and bit patterns.
    for (int i = 0; i < KP_NUM_LANES; i++) begin
      case (i)
        0: begin
          v = '0;
        end
        1: begin
          v = '1;
        end
        2: begin
          v = 64'h1;
        end
        3: begin
          v = 64'h8000_0000_0000_0000;
        end
        4: begin
          v = 64'hAAAA_AAAA_AAAA_AAAA;
        end
        5: begin
          v = 64'h5555_5555_5555_5555;
        end
        default: begin
          v = {$urandom(), $urandom()};
        end
      endcase
      push_txn(TXN_LANE, v, 0);
    end
    // No rounds at all: lanes must come back unchanged.
    push_txn(TXN_CFG, 64'd0, 0);
    push_state(1'b1, 1'b0);
    // Largest register value saturates to the full 24 rounds.
    push_txn(TXN_CFG, 64'd31, 0);
    push_state(1'b1, 1'b0);
    push_txn(TXN_CFG, 64'd1, 0);
    push_state(1'b0, 1'b0);
    // Just above the limit, on the all-zero state.
    push_txn(TXN_CFG, 64'd25, 0);
    push_state(1'b1, 1'b1);
    // Two states with the sender held off until the first has fully drained.
    push_txn(TXN_CFG, 64'd24, 0);
    push_state(1'b1, 1'b0);
    push_txn(TXN_DRAIN, '0, 0);
    push_state(1'b1, 1'b0);
    push_txn(TXN_CFG, 64'($urandom_range(2, 23)), 0);
    push_state(1'b1, 1'b0);
    push_state(1'b0, 1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (lane_txn_q.size() != 0 || start || busy || permuted_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && permuted_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Driver: presents queued transactions and feeds accepted lanes to the predictor.
  always @(posedge clk) begin : drive_proc
    logic nxt_start;
    logic nxt_cfg_en;
    if (!rst_n) begin
      start         <= 1'b0;
      cfg_wr_en     <= 1'b0;
      in_lane_value <= '0;
      cfg_wr_data   <= '0;
      rounds_cfg    = KP_CNT_W'(KP_MAX_ROUNDS);
      load_cnt      = 0;
      gap_cnt       = 0;
      quiet_cnt     = 0;
      for (int i = 0; i < KP_NUM_LANES; i++) begin
        state_lanes[i] = '0;
      end
    end else begin
      nxt_start  = start;
      nxt_cfg_en = 1'b0;
      if (cfg_wr_en) begin
        rounds_cfg = cfg_wr_data;
      end
      if (start && !busy) begin
        absorb_lane(in_lane_value);
        void'(lane_txn_q.pop_front());
        gap_cnt   = 0;
        nxt_start = 1'b0;
      end
      // Count idle cycles so that the register is only written to a quiet block.
      if (permuted_q.size() == 0 && !start && !busy) begin
        quiet_cnt++;
      end else begin
        quiet_cnt = 0;
      end
      if (!nxt_start && lane_txn_q.size() != 0) begin
        if (gap_cnt < lane_txn_q[0].gap) begin
          gap_cnt++;
        end else begin
          case (lane_txn_q[0].kind)
            TXN_LANE: begin
              nxt_start = 1'b1;
              in_lane_value <= lane_txn_q[0].value;
            end
            TXN_CFG: begin
              if (quiet_cnt >= SETTLE_CYCLES) begin
                nxt_cfg_en = 1'b1;
                cfg_wr_data <= lane_txn_q[0].value[KP_CNT_W-1:0];
                void'(lane_txn_q.pop_front());
                gap_cnt   = 0;
                quiet_cnt = 0;
              end
            end
            TXN_DRAIN: begin
              if (permuted_q.size() == 0) begin
                void'(lane_txn_q.pop_front());
                gap_cnt = 0;
              end
            end
            default: begin
              void'(lane_txn_q.pop_front());
            end
          endcase
        end
      end
      start     <= nxt_start;
      cfg_wr_en <= nxt_cfg_en;
    end
  end

  // Monitor: every result transaction is compared with the oldest predicted lane.
  always @(posedge clk) begin : check_proc
    lane_out_t want;
    if (rst_n && out_valid) begin
      if (permuted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected result: lane %0d value %h last %b",
                   out_lane_index, out_lane_result, out_last_lane);
        end
      end else begin
        want = permuted_q.pop_front();
        if (out_lane_result !== want.lane || out_lane_index !== want.idx
            || out_last_lane !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Mismatch: expected lane %0d value %h last %b", want.idx,
                     want.lane, want.last);
            $display("          got      lane %0d value %h last %b", out_lane_index,
                     out_lane_result, out_last_lane);
          end
        end
      end
    end
  end

endmodule

// File: filelist.f
design/kp_pkg.sv
design/kp_ctrl.sv
design/kp_datapath.sv
design/keccak_permutation_top.sv
tb/tb.sv
